// File: src/bcd_date_weekday_macros.svh
// Assertion macros for the BCD date to weekday block.
// Used by the checker that is bound to the top level; no other dependencies.
`ifndef BCD_DATE_WEEKDAY_MACROS_SVH
`define BCD_DATE_WEEKDAY_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define BCD_DW_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define BCD_DW_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/bcd_dw_pkg.sv
// Shared constants, types and the month start table for the BCD weekday block.
// No dependencies; imported by the calculation module and the top level.
`default_nettype none

package bcd_dw_pkg;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 8;
   localparam int RSP_TUSER_W = 1;

   localparam int DAY_W   = 6;
   localparam int MONTH_W = 5;
   localparam int YEAR_W  = 8;
   localparam int WDAY_W  = 3;
   localparam int DOY_W   = 9;

   typedef struct packed {
      logic [WDAY_W-1:0] weekday;
      logic              date_valid;
   } bcd_dw_result_type;

   // Days in the year before the first day of the given month, ignoring leap days.
   function automatic logic [DOY_W-1:0] month_start(input logic [3:0] month);
      logic [DOY_W-1:0] days;
      case (month)
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

`default_nettype wire

// File: src/bcd_dw_calc.sv
// Combinational date check and weekday calculation for one BCD date.
// Depends on bcd_dw_pkg for field widths, the result type and the month table.
`default_nettype none

module bcd_dw_calc (
   input  logic [bcd_dw_pkg::DAY_W-1:0]   bcd_day,
   input  logic [bcd_dw_pkg::MONTH_W-1:0] bcd_month,
   input  logic [bcd_dw_pkg::YEAR_W-1:0]  bcd_year,
   output bcd_dw_pkg::bcd_dw_result_type  result
);
   import bcd_dw_pkg::*;

   logic [1:0]       day_hi;
   logic [3:0]       day_lo;
   logic             month_hi;
   logic [3:0]       month_lo;
   logic [3:0]       year_hi;
   logic [3:0]       year_lo;
   logic [5:0]       day_bin;
   logic [4:0]       month_bin;
   logic [6:0]       year_bin;
   logic [5:0]       leap_count;
   logic [7:0]       year_plus3;
   logic             leap_add;
   logic [DOY_W-1:0] total;
   logic [4:0]       fold1;
   logic [3:0]       fold2;
   logic [2:0]       wday;
   logic             digits_ok;
   logic             range_ok;

   assign day_hi   = bcd_day[5:4];
   assign day_lo   = bcd_day[3:0];
   assign month_hi = bcd_month[4];
   assign month_lo = bcd_month[3:0];
   assign year_hi  = bcd_year[7:4];
   assign year_lo  = bcd_year[3:0];

   assign digits_ok = (day_lo <= 4'd9) && (month_lo <= 4'd9) &&
                      (year_lo <= 4'd9) && (year_hi <= 4'd9);

   assign day_bin   = ({4'd0, day_hi} << 3) + ({4'd0, day_hi} << 1) + {2'd0, day_lo};
   assign month_bin = {1'b0, month_lo} + (month_hi ? 5'd10 : 5'd0);
   assign year_bin  = ({3'd0, year_hi} << 3) + ({3'd0, year_hi} << 1) + {3'd0, year_lo};

   assign range_ok = (month_bin != 5'd0) && (month_bin <= 5'd12) &&
                     (day_bin != 6'd0) && (day_bin <= 6'd31);

   // Every fourth year of this century is a leap year, 2000 included.
   assign leap_add   = (year_bin[1:0] == 2'd0) && (month_bin > 5'd2);
   assign year_plus3 = {1'b0, year_bin} + 8'd3;
   assign leap_count = year_plus3[7:2];

   // 1 January 2000 was a Saturday.
   assign total = 9'd5 + {2'd0, year_bin} + {3'd0, leap_count} +
                  month_start(month_bin[3:0]) + {8'd0, leap_add} + {3'd0, day_bin};

   // Eight is one modulo seven, so octal digits can be summed.
   assign fold1 = {2'd0, total[8:6]} + {2'd0, total[5:3]} + {2'd0, total[2:0]};
   assign fold2 = {2'd0, fold1[4:3]} + {1'b0, fold1[2:0]};

   always_comb begin
      if (fold2 >= 4'd7) begin
         wday = 3'(fold2 - 4'd7);
      end else begin
         wday = fold2[2:0];
      end
   end

   always_comb begin
      result.date_valid = digits_ok && range_ok;
      result.weekday    = (digits_ok && range_ok) ? wday : 3'd0;
   end

endmodule

`default_nettype wire

// File: src/bcd_date_weekday.sv
// Weekday from a BCD calendar date: 0 is Sunday, 6 is Saturday.
// A word accepted on the request side passes through one input register and one result
// register, with the date calculation between them, before it raises rsp_tvalid.
// Throughput is one word per cycle; a stalled result holds while the input register fills.
// Reset clears both valid flags; payload registers are not reset.
// Depends on bcd_dw_pkg and bcd_dw_calc.
`default_nettype none

module bcd_date_weekday (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // bcd_day [5:0], bcd_month [10:6], bcd_year [18:11], zero [23:19]
   input  logic [bcd_dw_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // weekday [2:0], zero [7:3]
   output logic [bcd_dw_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // date_valid [0]
   output logic [bcd_dw_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import bcd_dw_pkg::*;

   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   logic [DAY_W-1:0]       s1_day_ff;
   logic [MONTH_W-1:0]     s1_month_ff;
   logic [YEAR_W-1:0]      s1_year_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   bcd_dw_result_type      rsp_result_ff;
   bcd_dw_result_type      calc_result;
   logic                   req_fire;
   logic                   rsp_load;

   assign rsp_load   = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || rsp_load;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (rsp_load) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_day_ff   <= req_tdata[5:0];
         s1_month_ff <= req_tdata[10:6];
         s1_year_ff  <= req_tdata[18:11];
      end
      if (rsp_load) begin
         rsp_result_ff <= calc_result;
      end
   end

   bcd_dw_calc u_calc (
      .bcd_day   (s1_day_ff),
      .bcd_month (s1_month_ff),
      .bcd_year  (s1_year_ff),
      .result    (calc_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-WDAY_W){1'b0}}, rsp_result_ff.weekday};
   assign rsp_tuser  = rsp_result_ff.date_valid;

endmodule

`default_nettype wire

// File: src/bcd_dw_checker.sv
// Port-level checks for the BCD weekday block, bound to the top level.
// Depends on bcd_date_weekday_macros.svh.
`default_nettype none
`include "bcd_date_weekday_macros.svh"

module bcd_dw_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic [0:0] rsp_tuser
);

   `BCD_DW_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp_tvalid, "result after reset")
   `BCD_DW_ASSERT_NR(a_reset_ready, clock, reset |=> req_tready, "not ready after reset")
   `BCD_DW_ASSERT(a_wday_range, clock, reset, rsp_tvalid |-> rsp_tdata < 8'd7, "bad weekday")
   `BCD_DW_ASSERT(a_invalid_zero, clock, reset,
      (rsp_tvalid && !rsp_tuser[0]) |-> rsp_tdata == 8'd0, "invalid date with weekday")
   `BCD_DW_ASSERT(a_stall_hold, clock, reset,
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "stalled word lost")

endmodule

bind bcd_date_weekday bcd_dw_checker u_bcd_dw_checker (.*);

`default_nettype wire
